// File: hw/rtl/tets_pkg.sv
// ----------------------------------------------------------------------------
// tets_pkg: timed event scheduler table package
// Shared field widths, command and result codes, and the structs that pass
// between the sequencer and the row of slot cells.
// ----------------------------------------------------------------------------
package tets_pkg;

	localparam int CMD_W   = 3;
	localparam int TIME_W  = 32;
	localparam int ID_W    = 29;
	localparam int LEN_W   = 4;
	localparam int DATA_W  = 64;
	localparam int SLOT_W  = 4;
	localparam int KIND_W  = 2;
	localparam int CFG_W   = 5;
	localparam int LIST_BYTES = 8;
	localparam int MAX_FIRE   = 16;
	localparam int FIRE_W     = 5;
	localparam logic [7:0] PAD_BYTE = 8'hFF;
	localparam logic [CFG_W-1:0] SLOTS_RESET = 5'd16;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD      = 3'd0,
		CMD_RM_SLOT  = 3'd1,
		CMD_RM_ID    = 3'd2,
		CMD_QUERY_ID = 3'd3,
		CMD_RD_TIME  = 3'd4,
		CMD_SET_TIME = 3'd5,
		CMD_CHECK    = 3'd6,
		CMD_NOP      = 3'd7
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD_STATUS = 2'd0,
		KIND_FIRED      = 2'd1,
		KIND_SLOT_LIST  = 2'd2,
		KIND_SLOT_TIME  = 2'd3
	} kind_t;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		cmd_t              op;
		logic              found;
		logic              fire_ok;
		logic              go;
		logic              adv;
		logic              stop;
		logic              rs_we;
		logic [TIME_W-1:0] latest;
		logic [TIME_W-1:0] ev_time;
		logic              bus;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
		logic [SLOT_W-1:0] slot;
	} cell_cmd_t;

	// Masked view of a cell; zero unless the cell holds the token or is read.
	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic              bus;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
		logic              free;
		logic              hit;
		logic              idm;
	} cell_tap_t;

endpackage

// File: hw/rtl/timed_event_scheduler_table.sv
// ----------------------------------------------------------------------------
// timed_event_scheduler_table: table of timed packet events
// A row of slot cells walked by a token, plus the command sequencer.
// ----------------------------------------------------------------------------
// Use:
//   Commands enter on the in_valid/in_ready channel, one item at a time;
//   in_ready is high only while the sequencer is idle. Results leave on the
//   out_valid/out_ready channel from an output register.
//   Add, remove by id, query id and check walk a token through the slot
//   cells, one cell per cycle while not stalled, visiting n cells, where n is
//   the number of slots in use (min of slots_in_use and EVENT_SLOTS).
//   Remove slot and read slot time skip the walk; set time stays idle.
//   An armed check emits due events in slot order, up to MAX_FIRE; each fired
//   event waits in a one-entry holding stage so the final one can carry last_fired.
//   If the receiver stalls, the walk holds at the current cell until the
//   output register drains; nothing is dropped. slots_in_use is written by
//   cfg_we/cfg_wdata only while idle, a rule on the user that the block
//   does not enforce. Reset (arst_n low) frees every slot, clears the stored
//   events, stored time and its fresh flag, and sets slots_in_use to 16.
// ----------------------------------------------------------------------------
module timed_event_scheduler_table #(
	parameter int EVENT_SLOTS  = 16,
	parameter int LIST_ENTRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [31:0] event_time,
	input  logic        send_on_bus,
	input  logic [28:0] packet_id,
	input  logic [3:0]  packet_length,
	input  logic [63:0] packet_data,
	input  logic [3:0]  slot_index,
	input  logic [31:0] time_value,
	input  logic        sequencing_enabled,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic        add_status,
	output logic [63:0] slot_list,
	output logic [31:0] slot_time,
	output logic        fire_to_bus,
	output logic [28:0] fired_id,
	output logic [3:0]  fired_length,
	output logic [63:0] fired_data,
	output logic        last_fired,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);

	localparam int CW = $clog2(EVENT_SLOTS + 1);
	localparam int NW = (CW > 5) ? CW : 5;
	localparam int PW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	typedef struct packed {
		tets_pkg::kind_t kind;
		logic            add_status;
		logic [63:0]     list;
		logic [31:0]     time_v;
		logic            bus;
		logic [28:0]     id;
		logic [3:0]      len;
		logic [63:0]     data;
		logic            last;
	} res_t;

	state_t            state_q;
	tets_pkg::cmd_t    op_q;
	logic [31:0]       ev_time_q;
	logic              bus_q;
	logic [28:0]       id_q;
	logic [3:0]        len_q;
	logic [63:0]       data_q;
	logic [3:0]        slot_q;
	logic [4:0]        slots_q;
	logic [31:0]       latest_q;
	logic              fresh_q;
	logic [PW-1:0]     pos_q;
	logic              found_q;
	logic [3:0]        cnt_q;
	logic [63:0]       list_q;
	logic [tets_pkg::FIRE_W-1:0] k_q;
	logic              pend_v_q;
	res_t              pend_q;
	logic              out_valid_q;
	res_t              out_q;

	tets_pkg::cell_cmd_t cmd;
	tets_pkg::cell_tap_t taps [EVENT_SLOTS];
	tets_pkg::cell_tap_t tap;
	logic [EVENT_SLOTS:0] tok;

	logic [NW-1:0] n;
	logic accept, out_free, last_step, fire, stall, go, start, scan_cmd, armed;
	logic need_emit, fin_done, out_load;
	res_t out_next, fire_res;
	tets_pkg::cmd_t in_cmd;

	// Row of slot cells; the token enters at cell 0 and moves right.
	assign tok[0] = start;
	for (genvar g = 0; g < EVENT_SLOTS; g++) begin : g_cell
		tets_cell #(.IDX(g)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.tok_in (tok[g]),
			.tok_out(tok[g+1]),
			.tap    (taps[g])
		);
	end

	// At most one cell drives a nonzero tap.
	always_comb begin
		tap = '0;
		for (int i = 0; i < EVENT_SLOTS; i++) begin
			tap = tap | taps[i];
		end
	end

	always_comb begin
		n = (NW'(slots_q) >= NW'(EVENT_SLOTS)) ? NW'(EVENT_SLOTS) : NW'(slots_q);
		in_cmd   = tets_pkg::cmd_t'(command);
		accept   = in_valid && in_ready;
		out_free = !out_valid_q || out_ready;
		armed    = sequencing_enabled && fresh_q;
		scan_cmd = (in_cmd == tets_pkg::CMD_ADD) || (in_cmd == tets_pkg::CMD_RM_ID) ||
			(in_cmd == tets_pkg::CMD_QUERY_ID) || ((in_cmd == tets_pkg::CMD_CHECK) && armed);
		start    = accept && scan_cmd && (n != '0);

		last_step = (NW'(pos_q) + NW'(1)) == n;
		fire  = (state_q == ST_SCAN) && (op_q == tets_pkg::CMD_CHECK) && tap.hit &&
			(k_q < tets_pkg::FIRE_W'(tets_pkg::MAX_FIRE));
		stall = fire && pend_v_q && !out_free;
		go    = (state_q == ST_SCAN) && !stall;

		fire_res        = '0;
		fire_res.kind   = tets_pkg::KIND_FIRED;
		fire_res.bus    = tap.bus;
		fire_res.id     = tap.id;
		fire_res.len    = tap.len;
		fire_res.data   = tap.data;

		need_emit = (op_q == tets_pkg::CMD_ADD) || (op_q == tets_pkg::CMD_QUERY_ID) ||
			(op_q == tets_pkg::CMD_RD_TIME) || ((op_q == tets_pkg::CMD_CHECK) && pend_v_q);
		fin_done  = (state_q == ST_FIN) && (!need_emit || out_free);

		// Build the result for the output register.
		out_next = '0;
		out_load = 1'b0;
		if (state_q == ST_SCAN) begin
			out_next      = pend_q;
			out_next.last = 1'b0;
			out_load      = go && fire && pend_v_q;
		end else if (state_q == ST_FIN) begin
			out_load = fin_done && need_emit;
			case (op_q)
				tets_pkg::CMD_ADD: begin
					out_next.kind       = tets_pkg::KIND_ADD_STATUS;
					out_next.add_status = !found_q;
				end
				tets_pkg::CMD_QUERY_ID: begin
					out_next.kind = tets_pkg::KIND_SLOT_LIST;
					out_next.list = list_q;
				end
				tets_pkg::CMD_RD_TIME: begin
					out_next.kind   = tets_pkg::KIND_SLOT_TIME;
					out_next.time_v = (NW'(slot_q) < n) ? tap.due : '0;
				end
				default: begin
					out_next      = pend_q;
					out_next.last = 1'b1;
				end
			endcase
		end

		cmd         = '0;
		cmd.op      = op_q;
		cmd.found   = found_q;
		cmd.fire_ok = k_q < tets_pkg::FIRE_W'(tets_pkg::MAX_FIRE);
		cmd.go      = go;
		cmd.adv     = (go && !last_step) || start;
		cmd.stop    = go && last_step;
		cmd.rs_we   = (state_q == ST_FIN) && (op_q == tets_pkg::CMD_RM_SLOT) &&
			(NW'(slot_q) < n);
		cmd.latest  = latest_q;
		cmd.ev_time = ev_time_q;
		cmd.bus     = bus_q;
		cmd.id      = id_q;
		cmd.len     = len_q;
		cmd.data    = data_q;
		cmd.slot    = slot_q;
	end

	assign in_ready = (state_q == ST_IDLE);

	// Sequencer and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= tets_pkg::CMD_NOP;
			slots_q  <= tets_pkg::SLOTS_RESET;
			latest_q <= '0;
			fresh_q  <= 1'b0;
			pos_q    <= '0;
			found_q  <= 1'b0;
			cnt_q    <= '0;
			list_q   <= '0;
			k_q      <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				slots_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q     <= in_cmd;
						pos_q    <= '0;
						found_q  <= 1'b0;
						cnt_q    <= '0;
						list_q   <= {tets_pkg::LIST_BYTES{tets_pkg::PAD_BYTE}};
						k_q      <= '0;
						pend_v_q <= 1'b0;
						if (in_cmd == tets_pkg::CMD_SET_TIME) begin
							latest_q <= time_value;
							fresh_q  <= 1'b1;
						end else if (start) begin
							state_q <= ST_SCAN;
						end else if (scan_cmd || (in_cmd == tets_pkg::CMD_RM_SLOT) ||
							(in_cmd == tets_pkg::CMD_RD_TIME)) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (go) begin
						pos_q <= pos_q + PW'(1);
						if (last_step) begin
							state_q <= ST_FIN;
						end
						if ((op_q == tets_pkg::CMD_ADD) && tap.free) begin
							found_q <= 1'b1;
						end
						if ((op_q == tets_pkg::CMD_QUERY_ID) && tap.idm &&
							(cnt_q < 4'(LIST_ENTRIES))) begin
							list_q[cnt_q[2:0]*8 +: 8] <= 8'(pos_q);
							cnt_q <= cnt_q + 4'd1;
						end
						if (fire) begin
							k_q      <= k_q + tets_pkg::FIRE_W'(1);
							pend_v_q <= 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (fin_done) begin
						state_q  <= ST_IDLE;
						pend_v_q <= 1'b0;
						if (op_q == tets_pkg::CMD_CHECK) begin
							fresh_q <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Holding stage for the newest fired event.
	always_ff @(posedge clk) begin
		if (go && fire) begin
			pend_q <= fire_res;
		end
	end

	// Latch the command fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			ev_time_q <= event_time;
			bus_q     <= send_on_bus;
			id_q      <= packet_id;
			len_q     <= packet_length;
			data_q    <= packet_data;
			slot_q    <= slot_index;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = out_q.kind;
	assign add_status   = out_q.add_status;
	assign slot_list    = out_q.list;
	assign slot_time    = out_q.time_v;
	assign fire_to_bus  = out_q.bus;
	assign fired_id     = out_q.id;
	assign fired_length = out_q.len;
	assign fired_data   = out_q.data;
	assign last_fired   = out_q.last;

endmodule

// File: hw/rtl/tets_cell.sv
// ----------------------------------------------------------------------------
// tets_cell: one event slot
// Holds one slot's event; acts on it while the scan token sits here or when
// its slot is addressed, and hands the token to the next cell on an advance.
// ----------------------------------------------------------------------------
module tets_cell #(
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tets_pkg::cell_cmd_t  cmd,
	input  logic                 tok_in,
	output logic                 tok_out,
	output tets_pkg::cell_tap_t  tap
);

	logic [tets_pkg::TIME_W-1:0] due_q;
	logic                        bus_q;
	logic [tets_pkg::ID_W-1:0]   id_q;
	logic [tets_pkg::LEN_W-1:0]  len_q;
	logic [tets_pkg::DATA_W-1:0] data_q;
	logic                        tok_q;

	logic free, hit, idm, slot_hit, sel, add_we, clr;

	always_comb begin
		free     = (due_q == '0);
		hit      = !free && (due_q <= cmd.latest);
		idm      = (id_q == cmd.id);
		slot_hit = ({28'd0, cmd.slot} == 32'(IDX));
		sel      = tok_q || ((cmd.op == tets_pkg::CMD_RD_TIME) && slot_hit);
		add_we   = tok_q && cmd.go && (cmd.op == tets_pkg::CMD_ADD) && !cmd.found && free;
		clr      = (tok_q && cmd.go &&
			(((cmd.op == tets_pkg::CMD_RM_ID) && idm) ||
			 ((cmd.op == tets_pkg::CMD_CHECK) && hit && cmd.fire_ok))) ||
			(cmd.rs_we && slot_hit);
		tap.due  = sel ? due_q : '0;
		tap.bus  = sel && bus_q;
		tap.id   = sel ? id_q : '0;
		tap.len  = sel ? len_q : '0;
		tap.data = sel ? data_q : '0;
		tap.free = tok_q && free;
		tap.hit  = tok_q && hit;
		tap.idm  = tok_q && idm;
	end

	assign tok_out = tok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_q  <= '0;
			bus_q  <= 1'b0;
			id_q   <= '0;
			len_q  <= '0;
			data_q <= '0;
			tok_q  <= 1'b0;
		end else begin
			if (add_we) begin
				due_q  <= cmd.ev_time;
				bus_q  <= cmd.bus;
				id_q   <= cmd.id;
				len_q  <= cmd.len;
				data_q <= cmd.data;
			end else if (clr) begin
				due_q <= '0;
			end
			if (cmd.stop) begin
				tok_q <= 1'b0;
			end else if (cmd.adv) begin
				tok_q <= tok_in;
			end
		end
	end

endmodule

// File: hw/rtl/tets_checker.sv
// ----------------------------------------------------------------------------
// tets_checker: port checks for the timed event scheduler table
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module tets_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_kind,
	input logic        add_status,
	input logic [63:0] slot_list,
	input logic [31:0] slot_time,
	input logic [28:0] fired_id,
	input logic        last_fired
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(slot_list))
		else $error("stalled result changed");

	// Only a fired event may carry last_fired or an id.
	a_fire_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind != tets_pkg::KIND_FIRED) |-> !last_fired && (fired_id == '0))
		else $error("fired fields on a non-fire result");

	// A slot time result has no list or status.
	a_time_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == tets_pkg::KIND_SLOT_TIME) |->
		(slot_list == '0) && !add_status)
		else $error("stray fields on slot time result");

	// An add status result carries no time.
	a_add_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == tets_pkg::KIND_ADD_STATUS) |-> (slot_time == '0))
		else $error("stray time on add status result");

endmodule

bind timed_event_scheduler_table tets_checker u_tets_checker (.*);
